// ===== src/slu_pkg.sv =====
package slu_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  reg_addr;
    logic [15:0] write_data;
    logic        rx_valid;
    logic [7:0]  rx_char;
  } slu_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        bus_error;
    logic        rx_taken;
    logic        tx_valid;
    logic [6:0]  tx_char;
    logic        rx_irq;
    logic        tx_irq;
  } slu_out_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } slu_cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_ARMED = 3'b010,
    PH_FIRED = 3'b100
  } slu_phase_e;

  localparam logic [2:0] AddrRxCsr = 3'd0;
  localparam logic [2:0] AddrRxBuf = 3'd2;
  localparam logic [2:0] AddrTxCsr = 3'd4;
  localparam logic [2:0] AddrTxBuf = 3'd6;

  localparam int unsigned DoneBit = 7;
  localparam int unsigned IeBit   = 6;

  localparam logic [15:0] TxCsrReset = 16'h0080;

  // Bit 7 of a control/status register is read-only.
  function automatic logic [15:0] merge_csr(input logic [15:0] old_val,
                                            input logic [15:0] wr_val);
    merge_csr = {wr_val[15:8], old_val[DoneBit], wr_val[6:0]};
  endfunction

endpackage

// ===== src/slu_in_reg.sv =====
module slu_in_reg
  import slu_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  slu_in_t in_data_i,
  input  logic    advance_i,
  output logic    valid_o,
  output slu_in_t data_o
);

  logic    valid_q, valid_d;
  slu_in_t data_q;

  // Take a new beat when empty or when the held one moves on.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/slu_core.sv =====
module slu_core
  import slu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  slu_in_t  item_i,
  output slu_out_t res_o
);

  logic [15:0] rx_csr_q, rx_csr_d;
  logic [15:0] tx_csr_q, tx_csr_d;
  logic [6:0]  rx_buf_q, rx_buf_d;
  logic [7:0]  tx_buf_q, tx_buf_d;
  slu_phase_e  phase_q, phase_d;
  logic [15:0] tx_merged;

  always_comb begin
    rx_csr_d  = rx_csr_q;
    tx_csr_d  = tx_csr_q;
    rx_buf_d  = rx_buf_q;
    tx_buf_d  = tx_buf_q;
    phase_d   = phase_q;
    res_o     = '0;
    tx_merged = merge_csr(tx_csr_q, item_i.write_data);
    case (slu_cmd_e'(item_i.command))
      CMD_TICK: begin
        if (!rx_csr_q[DoneBit] && item_i.rx_valid) begin
          rx_buf_d          = item_i.rx_char[6:0];
          rx_csr_d[DoneBit] = 1'b1;
          res_o.rx_taken    = 1'b1;
          res_o.rx_irq      = rx_csr_q[IeBit];
        end
        if (tx_buf_q != 8'd0) begin
          tx_csr_d[DoneBit] = 1'b1;
          tx_buf_d          = 8'd0;
          res_o.tx_irq      = tx_csr_q[IeBit];
        end else if (phase_q == PH_ARMED) begin
          res_o.tx_irq = 1'b1;
          phase_d      = PH_FIRED;
        end
      end
      CMD_READ: begin
        if (item_i.reg_addr[0]) begin
          res_o.bus_error = 1'b1;
        end else begin
          case (item_i.reg_addr)
            AddrRxCsr: res_o.read_data = rx_csr_q;
            AddrRxBuf: begin
              rx_csr_d[DoneBit] = 1'b0;
              res_o.read_data   = {9'd0, rx_buf_q};
            end
            AddrTxCsr: res_o.read_data = tx_csr_q;
            default:   res_o.read_data = {8'd0, tx_buf_q};
          endcase
        end
      end
      CMD_WRITE: begin
        if (item_i.reg_addr[0]) begin
          res_o.bus_error = 1'b1;
        end else begin
          case (item_i.reg_addr)
            AddrRxCsr: rx_csr_d = merge_csr(rx_csr_q, item_i.write_data);
            AddrRxBuf: ;
            AddrTxCsr: begin
              tx_csr_d = tx_merged;
              if (tx_merged[DoneBit] && tx_merged[IeBit] && phase_q == PH_IDLE) begin
                phase_d = PH_ARMED;
              end else if (phase_q == PH_FIRED) begin
                phase_d = PH_IDLE;
              end
            end
            default: begin
              res_o.tx_char     = item_i.write_data[6:0];
              res_o.tx_valid    = 1'b1;
              tx_buf_d          = {1'b1, item_i.write_data[6:0]};
              tx_csr_d[DoneBit] = 1'b0;
              phase_d           = PH_IDLE;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_csr_q <= '0;
      tx_csr_q <= TxCsrReset;
      rx_buf_q <= '0;
      tx_buf_q <= '0;
      phase_q  <= PH_IDLE;
    end else if (fire_i) begin
      rx_csr_q <= rx_csr_d;
      tx_csr_q <= tx_csr_d;
      rx_buf_q <= rx_buf_d;
      tx_buf_q <= tx_buf_d;
      phase_q  <= phase_d;
    end
  end

  // Transmitter ready exactly when no character is held in the buffer.
  a_tx_ready_buf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_csr_q[DoneBit] == (tx_buf_q == 8'd0))
    else $error("tx ready bit disagrees with tx buffer state");

  a_tx_buf_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_buf_q != 8'd0) |-> tx_buf_q[7])
    else $error("tx buffer holds a character without its busy mark");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("deferred interrupt phase lost its one-hot code");

  a_txbuf_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.command == CMD_WRITE && item_i.reg_addr == AddrTxBuf)
      |=> (phase_q == PH_IDLE))
    else $error("tx buffer write did not drop the deferred interrupt");

  a_irq_vs_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> !(res_o.tx_irq && res_o.tx_valid))
    else $error("transmit interrupt and transmit character in one beat");

endmodule

// ===== src/slu_out_reg.sv =====
module slu_out_reg
  import slu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_valid_i,
  input  slu_out_t load_data_i,
  output logic     advance_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output slu_out_t out_data_o
);

  logic     valid_q, valid_d;
  slu_out_t data_q;

  // Free to load when empty or when the held beat is taken now.
  assign advance_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = load_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && advance_o) begin
      data_q <= load_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/serial_line_unit_registers_top.sv =====
// Serial line unit register pair: receiver and transmitter control/status
// and buffer registers behind a valid/ready bus channel.
// Input channel: one beat per bus operation (tick, register read or register
// write) carrying command, reg_addr, write_data, rx_valid and rx_char.
// Output channel: exactly one result beat per input beat, in order, with
// read data, bus error, receive-taken, transmitted character and the two
// interrupt requests.
// Path: an accepted beat waits in the input register; when it moves on, the
// registers are updated and its result is loaded into the result register,
// which offers it on the output channel.
// Throughput: one beat per cycle while the receiver takes each result; the
// register update is a single shallow pass, so beats follow back to back.
// Reset (rst_ni low, asynchronous): rx status, both buffers clear, tx status
// reads ready (0x80), deferred interrupt idle, both stages empty.
// Receiver stall: the result register holds its beat; an empty input register
// still takes one more beat, then in_ready_o drops until the result goes.
module serial_line_unit_registers_top
  import slu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  slu_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output slu_out_t out_data_o
);

  logic     stage_valid;
  slu_in_t  stage_data;
  logic     advance;
  logic     fire;
  slu_out_t result;

  // Input register: hold the beat until the result register can take it.
  slu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .data_o     (stage_data)
  );

  // Commit the register update only when the beat moves on.
  assign fire = stage_valid && advance;

  slu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (stage_data),
    .res_o  (result)
  );

  slu_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (stage_valid),
    .load_data_i  (result),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== bench/slu_register_checker.sv =====
module slu_register_checker
  import slu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  slu_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  slu_out_t    out_data_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  // Shadow copy of the register file.
  logic [15:0] rx_csr;
  logic [15:0] tx_csr;
  logic [6:0]  rx_buf;
  logic [7:0]  tx_buf;
  slu_phase_e  tx_irq_phase;

  slu_out_t    expected_results[$];
  int unsigned mismatches = 0;

  // Keep bit 7 of the old value.
  function automatic logic [15:0] csr_after_write(input logic [15:0] old_val,
                                                  input logic [15:0] wr_val);
    logic [15:0] merged;
    merged          = wr_val;
    merged[DoneBit] = old_val[DoneBit];
    return merged;
  endfunction

  function automatic slu_out_t apply_bus_beat(input slu_in_t beat);
    slu_out_t res;
    res = '0;
    case (beat.command)
      CMD_TICK: begin
        if (!rx_csr[DoneBit] && beat.rx_valid) begin
          rx_buf          = beat.rx_char[6:0];
          rx_csr[DoneBit] = 1'b1;
          res.rx_taken    = 1'b1;
          res.rx_irq      = rx_csr[IeBit];
        end
        if (tx_buf != '0) begin
          tx_csr[DoneBit] = 1'b1;
          tx_buf          = '0;
          res.tx_irq      = tx_csr[IeBit];
        end else if (tx_irq_phase == PH_ARMED) begin
          res.tx_irq   = 1'b1;
          tx_irq_phase = PH_FIRED;
        end
      end
      CMD_READ, CMD_WRITE: begin
        if (beat.reg_addr[0]) begin
          res.bus_error = 1'b1;
        end else if (beat.command == CMD_READ) begin
          case (beat.reg_addr)
            AddrRxCsr: res.read_data = rx_csr;
            AddrRxBuf: begin
              rx_csr[DoneBit] = 1'b0;
              res.read_data   = {9'd0, rx_buf};
            end
            AddrTxCsr: res.read_data = tx_csr;
            default:   res.read_data = {8'd0, tx_buf};
          endcase
        end else begin
          case (beat.reg_addr)
            AddrRxCsr: rx_csr = csr_after_write(rx_csr, beat.write_data);
            AddrRxBuf: ;  // receive buffer is read-only
            AddrTxCsr: begin
              tx_csr = csr_after_write(tx_csr, beat.write_data);
              if (tx_csr[DoneBit] && tx_csr[IeBit] && tx_irq_phase == PH_IDLE) begin
                tx_irq_phase = PH_ARMED;
              end else if (tx_irq_phase == PH_FIRED) begin
                tx_irq_phase = PH_IDLE;
              end
            end
            default: begin
              res.tx_valid    = 1'b1;
              res.tx_char     = beat.write_data[6:0];
              tx_buf          = {1'b1, beat.write_data[6:0]};
              tx_csr[DoneBit] = 1'b0;
              tx_irq_phase    = PH_IDLE;
            end
          endcase
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slu_out_t want;
    if (!rst_ni) begin
      rx_csr        = '0;
      tx_csr        = TxCsrReset;
      rx_buf        = '0;
      tx_buf        = '0;
      tx_irq_phase  = PH_IDLE;
      expected_results.delete();
      outstanding_o <= 0;
      mismatches_o  <= 0;
    end else begin
      // Retire the result first: a beat accepted at this edge cannot leave yet.
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation waiting: 0x%0h", out_data_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("read_data", want.read_data, out_data_i.read_data);
          compare_field("bus_error", 16'(want.bus_error), 16'(out_data_i.bus_error));
          compare_field("rx_taken",  16'(want.rx_taken),  16'(out_data_i.rx_taken));
          compare_field("tx_valid",  16'(want.tx_valid),  16'(out_data_i.tx_valid));
          compare_field("tx_char",   16'(want.tx_char),   16'(out_data_i.tx_char));
          compare_field("rx_irq",    16'(want.rx_irq),    16'(out_data_i.rx_irq));
          compare_field("tx_irq",    16'(want.tx_irq),    16'(out_data_i.tx_irq));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(apply_bus_beat(in_data_i));
      end
      outstanding_o <= expected_results.size();
      mismatches_o  <= mismatches;
    end
  end

endmodule

// ===== bench/tb_serial_line_unit_registers_top.sv =====
module tb_serial_line_unit_registers_top;
  import slu_pkg::*;

  // Command code with no meaning: the block must ignore it entirely.
  localparam logic [1:0] CmdSpare  = 2'd3;
  // Odd addresses at either end of the range; both must raise a bus error.
  localparam logic [2:0] OddAddrLo = 3'd1;
  localparam logic [2:0] OddAddrHi = 3'd7;

  localparam int unsigned RandomBeats   = 400;
  localparam int unsigned StretchLength = 60;
  localparam int unsigned HoldOffAfter  = 120;
  localparam int unsigned HoldOffCycles = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  slu_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  slu_out_t    out_data;

  int unsigned mismatch_count;
  int unsigned results_outstanding;

  int unsigned beats_offered = 0;
  bit          sender_tight = 1'b0;
  bit          receiver_tight = 1'b0;

  serial_line_unit_registers_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  slu_register_checker checker_inst (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .mismatches_o  (mismatch_count),
    .outstanding_o (results_outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Offer one beat. Entered and left at a rising edge; valid stays high on
  // return so that a back-to-back beat never drops it within the same step.
  task automatic send_beat(input slu_in_t beat);
    int unsigned gap;
    gap = sender_tight ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (beat.command != CmdSpare) begin
      beats_offered++;
      // Alternate stretches of random gaps with stretches of none.
      if (beats_offered % StretchLength == 0) sender_tight = !sender_tight;
    end
  endtask

  // Unused fields carry random filler: the block must ignore them.
  task automatic bus_tick(input logic rx_valid, input logic [7:0] rx_char);
    slu_in_t beat;
    beat.command    = CMD_TICK;
    beat.reg_addr   = 3'($urandom_range(0, 7));
    beat.write_data = 16'($urandom_range(0, 65535));
    beat.rx_valid   = rx_valid;
    beat.rx_char    = rx_char;
    send_beat(beat);
  endtask

  task automatic bus_read(input logic [2:0] addr);
    slu_in_t beat;
    beat.command    = CMD_READ;
    beat.reg_addr   = addr;
    beat.write_data = 16'($urandom_range(0, 65535));
    beat.rx_valid   = 1'($urandom_range(0, 1));
    beat.rx_char    = 8'($urandom_range(0, 255));
    send_beat(beat);
  endtask

  task automatic bus_write(input logic [2:0] addr, input logic [15:0] data);
    slu_in_t beat;
    beat.command    = CMD_WRITE;
    beat.reg_addr   = addr;
    beat.write_data = data;
    beat.rx_valid   = 1'($urandom_range(0, 1));
    beat.rx_char    = 8'($urandom_range(0, 255));
    send_beat(beat);
  endtask

  task automatic bus_spare();
    slu_in_t beat;
    beat.command    = CmdSpare;
    beat.reg_addr   = 3'($urandom_range(0, 7));
    beat.write_data = 16'($urandom_range(0, 65535));
    beat.rx_valid   = 1'($urandom_range(0, 1));
    beat.rx_char    = 8'($urandom_range(0, 255));
    send_beat(beat);
  endtask

  // Mostly one of the four registers, now and then any address at all.
  function automatic logic [2:0] pick_addr();
    if ($urandom_range(0, 4) == 0) return 3'($urandom_range(0, 7));
    return {2'($urandom_range(0, 3)), 1'b0};
  endfunction

  // Control word with the interrupt enable set three times in four.
  function automatic logic [15:0] pick_csr_word();
    logic [15:0] word;
    word        = 16'($urandom_range(0, 65535));
    word[IeBit] = ($urandom_range(0, 3) != 0);
    return word;
  endfunction

  // Receiver: draw a stall per result; hold off once for a long stretch so
  // that both stages fill and the block drops its input ready.
  initial begin
    int unsigned stall;
    int unsigned results_taken;
    results_taken = 0;
    @(posedge rst_n);
    forever begin
      if (results_taken == HoldOffAfter) stall = HoldOffCycles;
      else stall = receiver_tight ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
      if (results_taken % (StretchLength - 10) == 0) receiver_tight = !receiver_tight;
    end
  end

  initial begin
    int unsigned pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, odd addresses and the spare command.
    bus_read(AddrRxCsr);
    bus_read(AddrTxCsr);
    bus_read(OddAddrLo);
    bus_write(OddAddrHi, 16'hFFFF);
    bus_spare();
    // Receive path: accept, refuse while done is set, clear done by reading.
    bus_write(AddrRxCsr, 16'hFFFF);
    bus_tick(1'b1, 8'hFF);
    bus_tick(1'b1, 8'h55);
    bus_read(AddrRxBuf);
    bus_tick(1'b1, 8'h80);
    // Deferred transmit interrupt: arm, fire once, disarm, re-arm.
    bus_write(AddrTxCsr, 16'hFFFF);
    bus_tick(1'b0, 8'hFF);
    bus_tick(1'b0, 8'h00);
    bus_write(AddrTxCsr, 16'h0040);
    bus_write(AddrTxCsr, 16'h0040);
    // Transmit a null, watch it busy, complete it; then the widest char.
    bus_write(AddrTxBuf, 16'h0000);
    bus_read(AddrTxBuf);
    bus_read(AddrTxCsr);
    bus_tick(1'b0, 8'h00);
    bus_write(AddrTxBuf, 16'hFFFF);
    bus_write(AddrRxBuf, 16'h1234);
    bus_tick(1'b1, 8'h00);
    bus_read(OddAddrLo);
    bus_write(AddrTxCsr, 16'h0000);
    bus_write(AddrRxCsr, 16'h0000);

    // Random part: mostly receive and transmit sequences with random
    // content, the rest single beats of any kind.
    beats_offered = 0;
    while (beats_offered < RandomBeats) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        bus_write(AddrRxCsr, pick_csr_word());
        bus_tick(1'b1, 8'($urandom_range(0, 255)));
        bus_read(AddrRxCsr);
        bus_read(AddrRxBuf);
      end else if (pick < 6) begin
        bus_write(AddrTxCsr, pick_csr_word());
        bus_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        bus_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        bus_write(AddrTxBuf, 16'($urandom_range(0, 65535)));
        bus_tick(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        bus_write(AddrTxCsr, pick_csr_word());
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 7) bus_tick(($urandom_range(0, 3) != 0), 8'($urandom_range(0, 255)));
        else if (pick < 12) bus_read(pick_addr());
        else if (pick < 19) bus_write(pick_addr(), 16'($urandom_range(0, 65535)));
        else bus_spare();
      end
    end
    in_valid <= 1'b0;

    // Drain: let the last beat reach the checker, then wait out the pipe.
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12 * 100000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
